### hw/rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Odometry package
// Shared constants, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int LEN_W = 40;
  localparam int ANG_W = 32;
  localparam int CFG_W = 12;
  localparam int CNT_W = 32;
  localparam int IDX_W = 1;

  localparam logic [IDX_W-1:0] REG_WHEEL_DIAMETER = 1'd0;
  localparam logic [IDX_W-1:0] REG_AXLE_LENGTH    = 1'd1;

  localparam logic [CFG_W-1:0] WHEEL_DIAMETER_RST = 12'd56;
  localparam logic [CFG_W-1:0] AXLE_LENGTH_RST    = 12'd120;

  localparam int CORDIC_ITERS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int ATAN_COUNT       = 24;

  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'h26DD3B6A;

  localparam logic signed [LEN_W-1:0] MAX40 = 40'sh7FFFFFFFFF;
  localparam logic signed [LEN_W-1:0] MIN40 = 40'sh8000000000;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// Differential drive odometry
// Turns absolute wheel encoder angles into pose, heading and total distance.
// ----------------------------------------------------------------------------
// Each input word carries the absolute left and right encoder angles. The
// block forms the wrapped deltas, scales the travel with a shift-add
// multiplier, finds the heading change with a shift-subtract divider, takes
// cosine and sine of the new heading with an iterative CORDIC, advances
// x and y with the same shift-add multiplier and adds the travel to distance.
// One word is worked on at a time. The work runs through a 45-step travel
// multiply, a 76-step divide that is skipped when the axle length is zero,
// the CORDIC and two 32-step multiplies. The next input word is taken in
// the cycle after the result is loaded into the output register.
// The result sits in an output register, so a stalled receiver does not
// block the next input; only if the previous result is still waiting when a
// new one is finished does the block hold until it is taken.
// Reset clears the pose, heading, distance and previous encoder angles and
// loads the default wheel diameter and axle length.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
  parameter int CORDIC_ITERS = ddo_pkg::CORDIC_ITERS_DEF,
  parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ddo_pkg::IDX_W-1:0]           cfg_index,
  input  logic [ddo_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ddo_pkg::CNT_W-1:0]    left_count,
  input  logic signed [ddo_pkg::CNT_W-1:0]    right_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ddo_pkg::LEN_W-1:0]    pos_x,
  output logic signed [ddo_pkg::LEN_W-1:0]    pos_y,
  output logic [ddo_pkg::ANG_W-1:0]           heading,
  output logic signed [ddo_pkg::LEN_W-1:0]    distance
);

  localparam int MRW = 45;
  localparam int DEN_W = 21;
  localparam int CW = 34;
  localparam logic [63:0] GAIN = (ddo_pkg::PI_Q62 >> (30 - FRAC_BITS)) / 64'd720;
  localparam int GW = $clog2(GAIN + 64'd1);
  localparam int MDW = (GW > 40) ? GW : 40;
  localparam int AW = MRW + MDW;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_TMUL, S_TRND, S_DIVA, S_DFIX, S_DIVB, S_DEND,
    S_CINIT, S_CORD, S_CFIN, S_XMUL, S_XRND, S_YMUL, S_YRND, S_OUT
  } state_t;

  state_t state;

  logic [ddo_pkg::CFG_W-1:0] wheel_diameter;
  logic [ddo_pkg::CFG_W-1:0] axle_length;
  logic [31:0] prev_left;
  logic [31:0] prev_right;
  logic signed [39:0] x_acc;
  logic signed [39:0] y_acc;
  logic [31:0] heading_acc;
  logic signed [39:0] distance_acc;

  logic signed [32:0] ssum;
  logic signed [32:0] sdiff;
  logic [MRW-1:0] mr;
  logic [MDW-1:0] md;
  logic [AW-1:0] acc;
  logic mneg;
  logic [5:0] cnt;
  logic [MRW-1:0] nmag;
  logic nneg;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic qb;
  logic [30:0] fq;
  logic signed [39:0] travel;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [CW-1:0] cz;
  logic flip;
  logic [31:0] smag;
  logic sneg;

  logic [31:0] dl;
  logic [31:0] dr;
  logic signed [44:0] prod_a;
  logic signed [44:0] prod_n;
  logic [AW-1:0] mul_add;
  logic [AW:0] rnd32;
  logic [AW:0] rnd30;
  logic [AW-32:0] tmag;
  logic ovp;
  logic signed [39:0] tsat;
  logic [40:0] lmag;
  logic signed [42:0] term;
  logic signed [42:0] x_sum;
  logic signed [42:0] y_sum;
  logic signed [42:0] d_sum;
  logic [DEN_W:0] div_r2;
  logic div_ge;
  logic [DEN_W:0] div_sub;
  logic round_up;
  logic [31:0] frac;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] atan;
  logic signed [CW-1:0] cos_v;
  logic signed [CW-1:0] sin_v;
  logic [CW-1:0] cmag_w;
  logic [CW-1:0] smag_w;
  logic [39:0] tabs;
  logic cflip;
  logic [31:0] cang;

  function automatic logic signed [39:0] sat40(input logic signed [42:0] v);
    logic signed [39:0] r;
    if (v[42:39] == 4'b0000 || v[42:39] == 4'b1111) begin
      r = v[39:0];
    end else if (v[42]) begin
      r = ddo_pkg::MIN40;
    end else begin
      r = ddo_pkg::MAX40;
    end
    return r;
  endfunction

  assign in_ready = (state == S_IDLE);

  always_comb begin
    dl = left_count - prev_left;
    dr = right_count - prev_right;
    prod_a = ssum * $signed({1'b0, wheel_diameter});
    prod_n = sdiff * $signed({1'b0, wheel_diameter});

    mul_add = {acc[AW-2:0], 1'b0} + (mr[MRW-1] ? AW'(md) : '0);
    rnd32 = {1'b0, acc} + ((AW+1)'(1) << 31);
    rnd30 = {1'b0, acc} + ((AW+1)'(1) << 29);

    tmag = rnd32[AW:32];
    ovp = |tmag[AW-32:39];
    if (ovp) begin
      tsat = mneg ? ddo_pkg::MIN40 : ddo_pkg::MAX40;
    end else begin
      tsat = mneg ? -$signed({1'b0, tmag[38:0]}) : $signed({1'b0, tmag[38:0]});
    end

    lmag = rnd30[70:30];
    term = mneg ? -$signed({2'b00, lmag}) : $signed({2'b00, lmag});
    x_sum = 43'(x_acc) + term;
    y_sum = 43'(y_acc) + term;
    d_sum = 43'(distance_acc) + 43'(tsat);

    div_r2 = {rem, (state == S_DIVA) ? nmag[MRW-1] : 1'b0};
    div_ge = (div_r2 >= {1'b0, den});
    div_sub = div_r2 - {1'b0, den};
    round_up = (({1'b0, rem} + {2'b00, den[DEN_W-1:1]}) >= {1'b0, den});
    frac = {1'b0, fq} + {31'd0, round_up};

    xs = cx >>> cnt[4:0];
    ys = cy >>> cnt[4:0];
    atan = $signed({2'b00, ddo_pkg::atan_entry(cnt[4:0])});
    cos_v = flip ? -cx : cx;
    sin_v = flip ? -cy : cy;
    cmag_w = cos_v[CW-1] ? 34'(-cos_v) : 34'(cos_v);
    smag_w = sin_v[CW-1] ? 34'(-sin_v) : 34'(sin_v);
    tabs = travel[39] ? 40'(-travel) : 40'(travel);

    cflip = heading_acc[31] ^ heading_acc[30];
    cang = {heading_acc[31] ^ cflip, heading_acc[30:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      wheel_diameter <= ddo_pkg::WHEEL_DIAMETER_RST;
      axle_length <= ddo_pkg::AXLE_LENGTH_RST;
      prev_left <= '0;
      prev_right <= '0;
      x_acc <= '0;
      y_acc <= '0;
      heading_acc <= '0;
      distance_acc <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ddo_pkg::REG_WHEEL_DIAMETER: wheel_diameter <= cfg_data;
          ddo_pkg::REG_AXLE_LENGTH:    axle_length <= cfg_data;
          default: ;
        endcase
      end
      if (out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ssum <= $signed({dl[31], dl}) + $signed({dr[31], dr});
            sdiff <= $signed({dr[31], dr}) - $signed({dl[31], dl});
            prev_left <= left_count;
            prev_right <= right_count;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          mr <= prod_a[44] ? MRW'(-prod_a) : MRW'(prod_a);
          mneg <= prod_a[44];
          nmag <= prod_n[44] ? MRW'(-prod_n) : MRW'(prod_n);
          nneg <= prod_n[44];
          den <= DEN_W'({9'd0, axle_length} * 21'd360);
          md <= MDW'(GAIN);
          acc <= '0;
          cnt <= 6'(MRW);
          state <= S_TMUL;
        end
        S_TMUL, S_XMUL, S_YMUL: begin
          acc <= mul_add;
          mr <= {mr[MRW-2:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            case (state)
              S_TMUL:  state <= S_TRND;
              S_XMUL:  state <= S_XRND;
              default: state <= S_YRND;
            endcase
          end
        end
        S_TRND: begin
          travel <= tsat;
          distance_acc <= sat40(d_sum);
          rem <= '0;
          cnt <= 6'(MRW);
          if (den != '0) begin
            state <= S_DIVA;
          end else begin
            state <= S_CINIT;
          end
        end
        S_DIVA, S_DIVB: begin
          rem <= div_ge ? div_sub[DEN_W-1:0] : div_r2[DEN_W-1:0];
          cnt <= cnt - 6'd1;
          if (state == S_DIVA) begin
            qb <= div_ge;
            nmag <= {nmag[MRW-2:0], 1'b0};
            if (cnt == 6'd1) begin
              state <= S_DFIX;
            end
          end else begin
            fq <= {fq[29:0], div_ge};
            if (cnt == 6'd1) begin
              state <= S_DEND;
            end
          end
        end
        S_DFIX: begin
          if (nneg && rem != '0) begin
            qb <= ~qb;
            rem <= den - rem;
          end
          fq <= '0;
          cnt <= 6'd31;
          state <= S_DIVB;
        end
        S_DEND: begin
          heading_acc <= heading_acc + {qb, 31'd0} + frac;
          state <= S_CINIT;
        end
        S_CINIT: begin
          flip <= cflip;
          cz <= $signed({{2{cang[31]}}, cang});
          cx <= $signed({2'b00, ddo_pkg::CORDIC_GAIN_Q30});
          cy <= '0;
          cnt <= '0;
          state <= S_CORD;
        end
        S_CORD: begin
          if (cz[CW-1]) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + atan;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - atan;
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(CORDIC_ITERS - 1)) begin
            state <= S_CFIN;
          end
        end
        S_CFIN: begin
          mr <= {cmag_w[31:0], (MRW-32)'(0)};
          md <= MDW'(tabs);
          mneg <= travel[39] ^ cos_v[CW-1];
          smag <= smag_w[31:0];
          sneg <= sin_v[CW-1];
          acc <= '0;
          cnt <= 6'd32;
          state <= S_XMUL;
        end
        S_XRND: begin
          x_acc <= sat40(x_sum);
          mr <= {smag, (MRW-32)'(0)};
          mneg <= travel[39] ^ sneg;
          acc <= '0;
          cnt <= 6'd32;
          state <= S_YMUL;
        end
        S_YRND: begin
          y_acc <= sat40(y_sum);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            pos_x <= x_acc;
            pos_y <= y_acc;
            heading <= heading_acc;
            distance <= distance_acc;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/ddo_checker.sv
// ----------------------------------------------------------------------------
// Odometry port checker
// Watches the ports of the odometry block for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module ddo_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [ddo_pkg::LEN_W-1:0] pos_x,
  input logic [ddo_pkg::ANG_W-1:0]        heading
);

  // After reset the block is empty and waits for a word.
  a_reset: assert property (@(posedge clk) rst |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

  // An accepted word keeps the block busy in the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a word");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pos_x) && $stable(heading)))
    else $error("stalled result changed");

  // A new result only appears when the block was working.
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pos_x     (pos_x),
  .heading   (heading)
);

### dv/differential_drive_odometry_test.sv
// ----------------------------------------------------------------------------
// Differential drive odometry testbench
// Drives encoder angle words into the block under random handshake gaps,
// predicts pose, heading and distance with an independent fixed-point model
// and compares every result word field by field.
// ----------------------------------------------------------------------------
module differential_drive_odometry_test;

  localparam int ITERS = ddo_pkg::CORDIC_ITERS_DEF;
  localparam int FRAC = ddo_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 195 + ITERS;

  typedef struct {
    logic signed [ddo_pkg::LEN_W-1:0] x;
    logic signed [ddo_pkg::LEN_W-1:0] y;
    logic [ddo_pkg::ANG_W-1:0] hdg;
    logic signed [ddo_pkg::LEN_W-1:0] travelled;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ddo_pkg::IDX_W-1:0] cfg_index = '0;
  logic [ddo_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ddo_pkg::CNT_W-1:0] left_count = '0;
  logic signed [ddo_pkg::CNT_W-1:0] right_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ddo_pkg::LEN_W-1:0] pos_x;
  logic signed [ddo_pkg::LEN_W-1:0] pos_y;
  logic [ddo_pkg::ANG_W-1:0] heading;
  logic signed [ddo_pkg::LEN_W-1:0] distance;

  differential_drive_odometry uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .left_count(left_count), .right_count(right_count),
    .out_valid(out_valid), .out_ready(out_ready), .pos_x(pos_x),
    .pos_y(pos_y), .heading(heading), .distance(distance)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [11:0] dia_q, axle_q;
  logic [31:0] last_left, last_right;
  logic signed [63:0] x_q, y_q, dist_q;
  logic [31:0] hdg_q;
  pose_t pose_queue[$];

  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  bit quiet_mode = 0;
  logic stalling = 1'b0;
  event hold_off;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %0s: got %0h expected %0h (word %0d)", what, got, want,
             words_checked);
    errors++;
  endtask

  function automatic logic signed [63:0] clamp40(input logic signed [127:0] v);
    if (v > 128'sd549755813887) return 64'sd549755813887;
    if (v < -128'sd549755813888) return -64'sd549755813888;
    return v[63:0];
  endfunction

  // (a*b) >> sh, rounded half away from zero, magnitude capped at 2^62.
  function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
      input logic signed [63:0] b, input int sh);
    logic neg;
    logic [127:0] ua, ub, p;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -{{64{a[63]}}, a} : {64'd0, a};
    ub = b < 0 ? -{{64{b[63]}}, b} : {64'd0, b};
    p = ((ua * ub) + (128'd1 << (sh - 1))) >> sh;
    if (p > (128'd1 << 62)) p = 128'd1 << 62;
    return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
  endfunction

  task automatic sin_cos(input logic [31:0] ang, output logic signed [63:0] c,
      output logic signed [63:0] s);
    logic flip;
    logic [31:0] a;
    logic signed [63:0] z, x, y, xs, ys;
    flip = ang[31] ^ ang[30];
    a = flip ? ang - 32'h80000000 : ang;
    z = $signed({{32{a[31]}}, a});
    x = $signed({32'd0, ddo_pkg::CORDIC_GAIN_Q30});
    y = 0;
    for (int i = 0; i < ITERS && i < ddo_pkg::ATAN_COUNT; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - $signed({32'd0, ddo_pkg::atan_entry(5'(i))});
      end else begin
        x = x + ys; y = y - xs; z = z + $signed({32'd0, ddo_pkg::atan_entry(5'(i))});
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_pose(input logic [31:0] lft, input logic [31:0] rgt);
    logic signed [63:0] dl, dr, dia, trav, n, den, qt, rm, c, s;
    logic [63:0] gain, frac;
    logic [31:0] dth, dlw, drw;
    pose_t p;
    dlw = lft - last_left;
    drw = rgt - last_right;
    dl = $signed({{32{dlw[31]}}, dlw});
    dr = $signed({{32{drw[31]}}, drw});
    dia = $signed({52'd0, dia_q});
    gain = (ddo_pkg::PI_Q62 >> (30 - FRAC)) / 720;
    trav = clamp40(mul_round((dl + dr) * dia, $signed(gain), 32));
    last_left = lft;
    last_right = rgt;
    dth = 0;
    if (axle_q != 0) begin
      n = (dr - dl) * dia;
      den = 360 * $signed({52'd0, axle_q});
      qt = n / den;
      rm = n % den;
      if (rm < 0) begin
        rm = rm + den; qt = qt - 1;
      end
      frac = ((rm << 31) + den / 2) / den;
      dth = 32'(qt << 31) + frac[31:0];
    end
    hdg_q = hdg_q + dth;
    sin_cos(hdg_q, c, s);
    x_q = clamp40(x_q + mul_round(trav, c, 30));
    y_q = clamp40(y_q + mul_round(trav, s, 30));
    dist_q = clamp40(dist_q + trav);
    p.x = x_q[39:0];
    p.y = y_q[39:0];
    p.hdg = hdg_q;
    p.travelled = dist_q[39:0];
    pose_queue.push_back(p);
  endtask

  task automatic send_word(input logic [31:0] lft, input logic [31:0] rgt);
    if (!quiet_mode && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 19)) @(posedge clk);
    predict_pose(lft, rgt);
    in_valid <= 1'b1;
    left_count <= lft;
    right_count <= rgt;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    words_sent++;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [ddo_pkg::IDX_W-1:0] idx, input logic [11:0] val);
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ddo_pkg::REG_WHEEL_DIAMETER) dia_q = val;
    else axle_q = val;
  endtask

  // Long receiver hold-off, counted in cycles.
  always begin
    @(hold_off);
    stalling <= 1'b1;
    repeat (600) @(posedge clk);
    stalling <= 1'b0;
  end

  // Receiver stalls and result checking.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pose_queue.size() == 0) begin
        report("unexpected result", 64'(pos_x), 64'd0);
      end else begin
        pose_t p;
        p = pose_queue.pop_front();
        if (pos_x !== p.x) report("pos_x", pos_x, p.x);
        if (pos_y !== p.y) report("pos_y", pos_y, p.y);
        if (heading !== p.hdg) report("heading", heading, p.hdg);
        if (distance !== p.travelled) report("distance", distance, p.travelled);
        words_checked++;
      end
    end
    if (stalling) begin
      out_ready <= 1'b0;
    end else if (quiet_mode) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 4) != 0);
    end
  end

  task automatic test_directed;
    send_word(32'd0, 32'd0);
    send_word(32'd360, 32'd360);
    send_word(32'd0, 32'd720);
    send_word(32'h7FFFFFFF, 32'h80000000);
    send_word(32'h80000000, 32'h7FFFFFFF);
    send_word(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_word(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_word(32'h80000000, 32'h80000000);
    send_word(32'h55555555, 32'hAAAAAAAA);
    send_word(32'hAAAAAAAA, 32'h55555555);
    send_word(32'd100, 32'd0);
  endtask

  task automatic test_extreme_config;
    write_reg(ddo_pkg::REG_WHEEL_DIAMETER, 12'd4095);
    write_reg(ddo_pkg::REG_AXLE_LENGTH, 12'd1);
    for (int i = 0; i < 4; i++) send_word($urandom, $urandom);
    write_reg(ddo_pkg::REG_AXLE_LENGTH, 12'd0);
    for (int i = 0; i < 4; i++) send_word($urandom, $urandom);
    send_word(32'h7FFFFFFF, 32'h7FFFFFFF);
    write_reg(ddo_pkg::REG_WHEEL_DIAMETER, 12'd0);
    write_reg(ddo_pkg::REG_AXLE_LENGTH, 12'd4095);
    for (int i = 0; i < 4; i++) send_word($urandom, $urandom);
  endtask

  // Mostly smooth motion with small deltas, some wild jumps.
  task automatic test_random(input int count);
    logic [31:0] l, r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        l = $urandom; r = $urandom;
      end else begin
        l = last_left + $urandom_range(0, 2000) - 1000;
        r = last_right + $urandom_range(0, 2000) - 1000;
      end
      send_word(l, r);
    end
  endtask

  task automatic test_random_configs;
    for (int k = 0; k < 4; k++) begin
      write_reg(ddo_pkg::REG_WHEEL_DIAMETER, 12'($urandom_range(1, 4095)));
      write_reg(ddo_pkg::REG_AXLE_LENGTH, 12'($urandom_range(1, 4095)));
      test_random(100);
    end
  endtask

  task automatic test_backpressure;
    -> hold_off;
    for (int i = 0; i < 5; i++) send_word($urandom, $urandom);
    while (pose_queue.size() != 0) @(posedge clk);
    test_random(10);
  endtask

  initial begin
    dia_q = ddo_pkg::WHEEL_DIAMETER_RST;
    axle_q = ddo_pkg::AXLE_LENGTH_RST;
    last_left = 0; last_right = 0;
    x_q = 0; y_q = 0; dist_q = 0; hdg_q = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extreme_config();
    test_backpressure();
    test_random_configs();
    quiet_mode = 1;
    write_reg(ddo_pkg::REG_WHEEL_DIAMETER, 12'd56);
    write_reg(ddo_pkg::REG_AXLE_LENGTH, 12'd120);
    test_random(60);
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d encoder words and checked %0d pose results over extreme,",
             words_sent, words_checked);
    $display("default and random wheel settings with input and output stalls.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d results outstanding", pose_queue.size());
    $display("status: fail");
    $finish;
  end
endmodule
